>>> rtl/crc_pkg.sv
package crc_pkg;

  // Field widths
  localparam int WORD_BITS = 32;
  localparam int POLY_BITS = 16;
  localparam int CHK_W     = 5;
  localparam int NSH_W     = $clog2(POLY_BITS);
  localparam int REM_W     = POLY_BITS - 1;
  localparam int WORK_W    = WORD_BITS + REM_W;

  // Division pipeline shape
  localparam int STEPS_PER_STAGE = 8;
  localparam int DIV_STAGES      = WORD_BITS / STEPS_PER_STAGE;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_BITS = 1'b1;

  localparam logic [POLY_BITS-1:0] POLY_RESET  = 16'd11;
  localparam logic [CHK_W-1:0]     CHECK_RESET = 5'd3;

  // Opcodes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Polynomial moved up so its top set bit sits at bit POLY_BITS-1
  typedef struct packed {
    logic [POLY_BITS-1:0] pn;
    logic [NSH_W-1:0]     nsh;
    logic                 zero;
  } crc_norm_t;

  // Request as it travels down the division pipeline
  typedef struct packed {
    logic                 opcode;
    logic                 bad;
    logic [WORD_BITS-1:0] dividend;
    logic [WORK_W-1:0]    work;
  } crc_stage_t;

  function automatic crc_norm_t poly_normalize(input logic [POLY_BITS-1:0] poly);
    crc_norm_t        n;
    logic [NSH_W-1:0] top;
    top = '0;
    for (int i = 0; i < POLY_BITS; i++) begin
      if (poly[i]) top = NSH_W'(i);
    end
    n.nsh  = NSH_W'(POLY_BITS - 1) - top;
    n.pn   = poly << n.nsh;
    n.zero = (poly == '0);
    return n;
  endfunction

  // One long-division step: cancel the top bit, then shift up
  function automatic logic [WORK_W-1:0] div_step(input logic [WORK_W-1:0] work,
                                                 input logic [POLY_BITS-1:0] pn);
    logic [WORK_W-1:0] w;
    w = work;
    if (w[WORK_W-1]) w[WORK_W-1 -: POLY_BITS] = w[WORK_W-1 -: POLY_BITS] ^ pn;
    return w << 1;
  endfunction

endpackage

>>> rtl/crc_in_if.sv
interface crc_in_if import crc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [WORD_BITS-1:0] word;

  modport source (output valid, output opcode, output word, input ready);
  modport sink (input valid, input opcode, input word, output ready);
endinterface

>>> rtl/crc_out_if.sv
interface crc_out_if import crc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] codeword;
  logic [POLY_BITS-1:0] remainder;
  logic                 ok;
  logic                 bad_poly;

  modport source (output valid, output codeword, output remainder, output ok,
                  output bad_poly, input ready);
  modport sink (input valid, input codeword, input remainder, input ok,
                input bad_poly, output ready);
endinterface

>>> rtl/crc_div_stage.sv
module crc_div_stage import crc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [POLY_BITS-1:0] poly_norm,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  crc_stage_t           up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output crc_stage_t           dn_data
);

  logic       valid_r;
  crc_stage_t data_r;
  crc_stage_t data_nxt;

  // Run this stage's share of the division steps
  always_comb begin
    data_nxt = up_data;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      data_nxt.work = div_step(data_nxt.work, poly_norm);
    end
  end

  // Advance when empty or when the next stage takes the request
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/crc_encode_check.sv
// CRC encoder and checker with a programmable generator polynomial (up to 16 bits)
// and check length. Accepts one request per clock when the output is not stalled
// and returns one result per request, in order, through these stages:
// one entry stage that shifts and aligns the word, four division stages of eight
// GF(2) steps each (32 steps for the 32-bit word), and one output register.
// Backpressure on the result channel stalls the pipeline stage by stage without
// losing requests. Write generator_poly (index 0) and check_bits (index 1) only
// while no request is in flight; a zero polynomial returns bad_poly with all
// other result fields zero.
module crc_encode_check import crc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  crc_in_if.sink               in_ch,
  crc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [POLY_BITS-1:0] cfg_data
);

  crc_norm_t        norm_r;
  logic [CHK_W-1:0] check_bits_r;

  // Configuration: keep the polynomial in aligned form
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r       <= poly_normalize(POLY_RESET);
      check_bits_r <= CHECK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GEN_POLY:   norm_r       <= poly_normalize(cfg_data);
        CFG_CHECK_BITS: check_bits_r <= cfg_data[CHK_W-1:0];
        default:        ;
      endcase
    end
  end

  logic       stg_valid [DIV_STAGES+1];
  logic       stg_ready [DIV_STAGES+1];
  crc_stage_t stg_data  [DIV_STAGES+1];

  // Entry stage: shift for encode and align the dividend to the polynomial
  logic                 s0_valid_r;
  crc_stage_t           s0_data_r;
  crc_stage_t           s0_nxt;
  logic [WORD_BITS-1:0] shifted;

  always_comb begin
    shifted         = in_ch.word << check_bits_r;
    s0_nxt.opcode   = in_ch.opcode;
    s0_nxt.bad      = norm_r.zero;
    s0_nxt.dividend = (in_ch.opcode == OP_CHECK) ? in_ch.word : shifted;
    s0_nxt.work     = {{REM_W{1'b0}}, s0_nxt.dividend} << norm_r.nsh;
  end

  assign in_ch.ready = !s0_valid_r || stg_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_data_r <= s0_nxt;
    end
  end

  assign stg_valid[0] = s0_valid_r;
  assign stg_data[0]  = s0_data_r;

  // Division pipeline
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    crc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .poly_norm (norm_r.pn),
      .up_valid  (stg_valid[g]),
      .up_ready  (stg_ready[g]),
      .up_data   (stg_data[g]),
      .dn_valid  (stg_valid[g+1]),
      .dn_ready  (stg_ready[g+1]),
      .dn_data   (stg_data[g+1])
    );
  end

  // Output stage: undo the alignment and form the result
  crc_stage_t           last;
  logic [POLY_BITS-1:0] rem;
  logic                 enc_ok;
  logic [WORD_BITS-1:0] code_nxt;
  logic [POLY_BITS-1:0] rem_nxt;
  logic                 ok_nxt;
  logic                 bad_nxt;

  always_comb begin
    last     = stg_data[DIV_STAGES];
    rem      = {1'b0, last.work[WORK_W-1 -: REM_W]} >> norm_r.nsh;
    enc_ok   = ((rem >> check_bits_r) == '0);
    code_nxt = '0;
    rem_nxt  = '0;
    ok_nxt   = 1'b0;
    bad_nxt  = 1'b0;
    priority if (last.bad) begin
      bad_nxt = 1'b1;
    end else if (last.opcode == OP_ENCODE) begin
      rem_nxt  = rem;
      ok_nxt   = enc_ok;
      code_nxt = enc_ok ? (last.dividend | {{(WORD_BITS-POLY_BITS){1'b0}}, rem})
                        : last.dividend;
    end else begin
      rem_nxt = rem;
      ok_nxt  = (rem == '0);
    end
  end

  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_code_r;
  logic [POLY_BITS-1:0] out_rem_r;
  logic                 out_ok_r;
  logic                 out_bad_r;

  assign stg_ready[DIV_STAGES] = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_ready[DIV_STAGES]) begin
      out_valid_r <= stg_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[DIV_STAGES] && stg_valid[DIV_STAGES]) begin
      out_code_r <= code_nxt;
      out_rem_r  <= rem_nxt;
      out_ok_r   <= ok_nxt;
      out_bad_r  <= bad_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.codeword  = out_code_r;
  assign out_ch.remainder = out_rem_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.bad_poly  = out_bad_r;

endmodule

>>> rtl/crc_chk.sv
module crc_chk import crc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] out_codeword,
  input logic [POLY_BITS-1:0] out_remainder,
  input logic                 out_ok,
  input logic                 out_bad_poly
);

  // Drop any result while in reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_codeword) &&
      $stable(out_remainder) && $stable(out_ok) && $stable(out_bad_poly))
    else $error("stalled result changed");

  // Zero polynomial clears every other field
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_poly |-> out_codeword == '0 && out_remainder == '0 && !out_ok)
    else $error("bad_poly result carries data");

  // A passing result carries its remainder in the low codeword bits
  a_ok_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |->
      (out_codeword[POLY_BITS-1:0] & out_remainder) == out_remainder)
    else $error("remainder missing from codeword");

  // A failing result with a nonzero polynomial always has a nonzero remainder
  a_fail_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok && !out_bad_poly |-> out_remainder != '0)
    else $error("failed result with zero remainder");

endmodule

bind crc_encode_check crc_chk u_crc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_codeword  (out_ch.codeword),
  .out_remainder (out_ch.remainder),
  .out_ok        (out_ch.ok),
  .out_bad_poly  (out_ch.bad_poly)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crc_pkg::*;

  localparam int PIPE_LATENCY = 6;
  localparam int STALL_LIMIT  = 5000;
  localparam int IDLE_PCT     = 31;

  typedef struct packed {
    logic [WORD_BITS-1:0] codeword;
    logic [POLY_BITS-1:0] remainder;
    logic                 ok;
    logic                 bad_poly;
  } crc_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [POLY_BITS-1:0] cfg_data;

  crc_in_if  in_ch ();
  crc_out_if out_ch ();

  crc_encode_check DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the configuration registers
  logic [POLY_BITS-1:0] gen_poly_q;
  logic [CHK_W-1:0]     check_bits_q;

  crc_result_t crc_expected[$];
  int          fail_count;
  int          quiet_cycles;
  bit          quiet_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // GF(2) long division by a nonzero polynomial, aligned to its top set bit
  function automatic logic [POLY_BITS-1:0] gf2_remainder(logic [WORD_BITS-1:0] dividend,
                                                         logic [POLY_BITS-1:0] poly);
    int                   deg;
    logic [WORD_BITS-1:0] acc;
    deg = 0;
    for (int i = 0; i < POLY_BITS; i++) begin
      if (poly[i]) deg = i;
    end
    acc = dividend;
    for (int i = WORD_BITS - 1; i >= deg; i--) begin
      if (acc[i]) acc = acc ^ (WORD_BITS'(poly) << (i - deg));
    end
    return acc[POLY_BITS-1:0];
  endfunction

  function automatic crc_result_t crc_predict(logic op, logic [WORD_BITS-1:0] word);
    crc_result_t          res;
    logic [WORD_BITS-1:0] shifted;
    res = '0;
    if (gen_poly_q == '0) begin
      res.bad_poly = 1'b1;
    end else if (op == OP_ENCODE) begin
      shifted       = word << check_bits_q;
      res.remainder = gf2_remainder(shifted, gen_poly_q);
      if (64'(res.remainder) < (64'd1 << check_bits_q)) begin
        res.codeword = shifted | WORD_BITS'(res.remainder);
        res.ok       = 1'b1;
      end else begin
        res.codeword = shifted;
      end
    end else begin
      res.remainder = gf2_remainder(word, gen_poly_q);
      res.ok        = (res.remainder == '0);
    end
    return res;
  endfunction

  // Send one request, idling at random first, and record its expected result
  task automatic send_request(logic op, logic [WORD_BITS-1:0] word);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.opcode = op;
    in_ch.word   = word;
    do @(posedge clk); while (!in_ch.ready);
    crc_expected.push_back(crc_predict(op, word));
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (crc_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POLY_BITS-1:0] data);
    drain_results();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_GEN_POLY) gen_poly_q = data;
    else check_bits_q = data[CHK_W-1:0];
  endtask

  function automatic logic [WORD_BITS-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
      3:       return WORD_BITS'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POLY_BITS-1:0] random_poly();
    case ($urandom_range(15))
      0:       return '0;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'h8000 | POLY_BITS'($urandom);
      4:       return POLY_BITS'($urandom_range(2, 15));
      default: return POLY_BITS'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [POLY_BITS-1:0] random_check_bits();
    case ($urandom_range(11))
      0:       return '0;
      1:       return POLY_BITS'($urandom_range(17, 31));
      2:       return POLY_BITS'($urandom);
      default: return POLY_BITS'($urandom_range(1, 16));
    endcase
  endfunction

  // Values after reset: generator 11, three check bits
  task automatic test_reset_values();
    crc_result_t enc;
    enc = crc_predict(OP_ENCODE, 32'h1234_5678);
    send_request(OP_ENCODE, 32'h0000_0000);
    send_request(OP_CHECK, 32'h0000_0000);
    send_request(OP_ENCODE, 32'hFFFF_FFFF);
    send_request(OP_ENCODE, 32'h8000_0000);
    send_request(OP_CHECK, enc.codeword);
    send_request(OP_CHECK, 32'hFFFF_FFFF);
  endtask

  // Zero polynomial flags bad_poly; degree zero gives zero remainders
  task automatic test_degenerate_polys();
    write_reg(CFG_GEN_POLY, 16'h0000);
    send_request(OP_ENCODE, 32'hA5A5_A5A5);
    send_request(OP_CHECK, 32'h5A5A_5A5A);
    write_reg(CFG_GEN_POLY, 16'h0001);
    send_request(OP_ENCODE, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 32'h8000_0001);
  endtask

  task automatic test_check_bits_extremes();
    crc_result_t enc;
    write_reg(CFG_GEN_POLY, 16'h8005);
    write_reg(CFG_CHECK_BITS, 16'd0);
    send_request(OP_ENCODE, 32'hDEAD_BEEF);
    send_request(OP_ENCODE, 32'h0000_0000);
    write_reg(CFG_CHECK_BITS, 16'd1);
    send_request(OP_ENCODE, 32'h8000_0001);
    write_reg(CFG_GEN_POLY, 16'hFFFF);
    write_reg(CFG_CHECK_BITS, 16'd16);
    send_request(OP_ENCODE, 32'hFFFF_FFFF);
    enc = crc_predict(OP_ENCODE, 32'h0000_C3A5);
    send_request(OP_CHECK, enc.codeword);
    write_reg(CFG_CHECK_BITS, 16'd31);
    send_request(OP_ENCODE, 32'h0000_0001);
    send_request(OP_ENCODE, 32'hFFFF_FFFF);
    // upper data bits beyond the register width are dropped
    write_reg(CFG_CHECK_BITS, 16'hFFE4);
    send_request(OP_ENCODE, 32'h7FFF_FFFE);
  endtask

  // Encodes, checks of a predicted codeword (some corrupted), and some noise checks
  task automatic test_random_phases();
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] code;
    crc_result_t          enc;
    for (int phase = 0; phase < 14; phase++) begin
      write_reg(CFG_GEN_POLY, random_poly());
      write_reg(CFG_CHECK_BITS, random_check_bits());
      quiet_mode = (phase == 6);
      for (int k = 0; k < 122; k++) begin
        // hold the sender until the pipeline has emptied
        if (k == 61 && phase % 3 == 1) drain_results();
        word = random_word();
        case ($urandom_range(9))
          0, 1, 2, 3: send_request(OP_ENCODE, word);
          4, 5, 6, 7: begin
            enc  = crc_predict(OP_ENCODE, word);
            code = enc.codeword;
            if ($urandom_range(3) == 0) code[$urandom_range(WORD_BITS - 1)] ^= 1'b1;
            send_request(OP_CHECK, code);
          end
          default: send_request(OP_CHECK, word);
        endcase
      end
      quiet_mode = 1'b0;
    end
  endtask

  // Result channel stalls at random except in the quiet stretch
  always @(negedge clk) begin
    out_ch.ready = quiet_mode || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    crc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (crc_expected.size() == 0) begin
        $error("unexpected result: codeword %h remainder %h", out_ch.codeword,
               out_ch.remainder);
        fail_count++;
      end else begin
        want = crc_expected.pop_front();
        if (out_ch.codeword !== want.codeword) begin
          $error("codeword: expected %h, got %h", want.codeword, out_ch.codeword);
          fail_count++;
        end
        if (out_ch.remainder !== want.remainder) begin
          $error("remainder: expected %h, got %h", want.remainder, out_ch.remainder);
          fail_count++;
        end
        if (out_ch.ok !== want.ok) begin
          $error("ok: expected %b, got %b", want.ok, out_ch.ok);
          fail_count++;
        end
        if (out_ch.bad_poly !== want.bad_poly) begin
          $error("bad_poly: expected %b, got %b", want.bad_poly, out_ch.bad_poly);
          fail_count++;
        end
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_GEN_POLY;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_ENCODE;
    in_ch.word   = '0;
    out_ch.ready = 1'b1;
    gen_poly_q   = POLY_RESET;
    check_bits_q = CHECK_RESET;
    fail_count   = 0;
    quiet_cycles = 0;
    quiet_mode   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_degenerate_polys();
    test_check_bits_extremes();
    test_random_phases();

    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (fail_count == 0 && crc_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/crc_pkg.sv
rtl/crc_in_if.sv
rtl/crc_out_if.sv
rtl/crc_div_stage.sv
rtl/crc_encode_check.sv
rtl/crc_chk.sv
verif/tb_top.sv
